### rtl/pqnp_pkg.sv
package pqnp_pkg;

   localparam int NumEntries = 6;
   localparam int NumPairs   = NumEntries / 2;
   localparam int ChanW      = 8;
   localparam int NumChans   = 3;
   localparam int ColorW     = NumChans * ChanW;
   localparam int CodeW      = 4;
   localparam int ByteW      = 2 * CodeW;
   localparam int SqW        = 2 * ChanW;
   localparam int DistW      = SqW + 2;
   localparam int CsrIndexW  = 3;

   typedef logic [ChanW-1:0]                  chan_type;
   typedef logic [CodeW-1:0]                  code_type;
   typedef logic [DistW-1:0]                  dist_type;
   typedef logic [ColorW-1:0]                 color_type;
   typedef logic [NumEntries-1:0][ColorW-1:0] palette_type;
   typedef logic [NumEntries-1:0][CodeW-1:0]  code_table_type;

   localparam code_type CodeBlack  = 4'h0;
   localparam code_type CodeWhite  = 4'h1;
   localparam code_type CodeYellow = 4'h2;
   localparam code_type CodeRed    = 4'h3;
   localparam code_type CodeBlue   = 4'h5;
   localparam code_type CodeGreen  = 4'h6;
   localparam code_type CodePad    = 4'h0;

   localparam code_table_type EntryCode =
      {CodeGreen, CodeBlue, CodeRed, CodeYellow, CodeWhite, CodeBlack};

   localparam palette_type EntryReset =
      {24'h00FF00, 24'h0000FF, 24'hFF0000, 24'hFFFF00, 24'hFFFFFF, 24'h000000};

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
      logic     final_pixel;
   } pixel_type;

   typedef struct packed {
      code_type code;
      logic     final_pixel;
   } code_item_type;

endpackage

### rtl/pqnp_req_if.sv
interface pqnp_req_if import pqnp_pkg::*;;
   logic     valid;
   logic     ready;
   chan_type red;
   chan_type green;
   chan_type blue;
   logic     final_pixel;

   modport source (output valid, output red, output green, output blue,
                   output final_pixel, input ready);
   modport sink (input valid, input red, input green, input blue,
                 input final_pixel, output ready);
endinterface

### rtl/pqnp_rsp_if.sv
interface pqnp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] packed_byte;
   logic       final_byte;

   modport source (output valid, output packed_byte, output final_byte, input ready);
   modport sink (input valid, input packed_byte, input final_byte, output ready);
endinterface

### rtl/pqnp_nearest.sv
module pqnp_nearest import pqnp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  pixel_type     in_pixel,
   input  palette_type   palette,
   output logic          out_valid,
   input  logic          out_ready,
   output code_item_type out_item
);

   localparam int Stages = 5;

   logic [Stages-1:0] valid_ff, valid_in;
   logic [Stages:0]   adv;
   logic [Stages-1:0] last_ff;

   pixel_type                                  pix_ff;
   logic [NumChans-1:0][ChanW-1:0]             pix_chan;
   logic [NumEntries-1:0][NumChans-1:0][SqW-1:0] sq_ff, sq_in;
   logic [NumEntries-1:0][DistW-1:0]           dist_ff, dist_in;
   logic [NumPairs-1:0][DistW-1:0]             pair_dist_ff, pair_dist_in;
   logic [NumPairs-1:0][CodeW-1:0]             pair_code_ff, pair_code_in;
   code_type                                   code_ff, code_in;

   always_comb begin
      adv[Stages] = out_ready;
      for (int k = Stages - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in[0] = adv[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < Stages; k++) begin
         if (adv[k]) begin
            valid_in[k] = valid_ff[k-1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   assign pix_chan = {pix_ff.red, pix_ff.green, pix_ff.blue};

   always_comb begin
      chan_type pal_chan;
      chan_type diff;
      for (int e = 0; e < NumEntries; e++) begin
         for (int c = 0; c < NumChans; c++) begin
            pal_chan     = palette[e][c*ChanW +: ChanW];
            diff         = (pix_chan[c] >= pal_chan) ? pix_chan[c] - pal_chan
                                                     : pal_chan - pix_chan[c];
            sq_in[e][c]  = SqW'(diff) * SqW'(diff);
         end
      end
   end

   always_comb begin
      for (int e = 0; e < NumEntries; e++) begin
         dist_in[e] = DistW'(sq_ff[e][0]) + DistW'(sq_ff[e][1]) + DistW'(sq_ff[e][2]);
      end
   end

   // The earlier entry of a pair keeps its place unless the later one is strictly closer.
   always_comb begin
      for (int p = 0; p < NumPairs; p++) begin
         if (dist_ff[2*p+1] < dist_ff[2*p]) begin
            pair_dist_in[p] = dist_ff[2*p+1];
            pair_code_in[p] = EntryCode[2*p+1];
         end else begin
            pair_dist_in[p] = dist_ff[2*p];
            pair_code_in[p] = EntryCode[2*p];
         end
      end
   end

   always_comb begin
      dist_type best_dist;
      best_dist = pair_dist_ff[0];
      code_in   = pair_code_ff[0];
      for (int p = 1; p < NumPairs; p++) begin
         if (pair_dist_ff[p] < best_dist) begin
            best_dist = pair_dist_ff[p];
            code_in   = pair_code_ff[p];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      if (adv[0]) begin
         pix_ff     <= in_pixel;
         last_ff[0] <= in_pixel.final_pixel;
      end
      if (adv[1]) begin
         sq_ff      <= sq_in;
         last_ff[1] <= last_ff[0];
      end
      if (adv[2]) begin
         dist_ff    <= dist_in;
         last_ff[2] <= last_ff[1];
      end
      if (adv[3]) begin
         pair_dist_ff <= pair_dist_in;
         pair_code_ff <= pair_code_in;
         last_ff[3]   <= last_ff[2];
      end
      if (adv[4]) begin
         code_ff    <= code_in;
         last_ff[4] <= last_ff[3];
      end
   end

   assign in_ready              = adv[0];
   assign out_valid             = valid_ff[Stages-1];
   assign out_item.code         = code_ff;
   assign out_item.final_pixel  = last_ff[Stages-1];

   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[Stages-1] && !out_ready) |=> valid_ff[Stages-1] && $stable(code_ff))
      else $error("nearest code changed while held at the pipeline end");

   assert property (@(posedge clock) disable iff (reset)
      (in_valid && adv[0]) |=> valid_ff[0])
      else $error("accepted pixel did not enter the first stage");

   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[3] && adv[4]) |=> valid_ff[4])
      else $error("pair result lost on its way to the code stage");

endmodule

### rtl/palette_quantize_nibble_pack.sv
// Nearest-palette quantizer: each item is one RGB888 pixel, matched by squared distance
// against six palette colors (CSR indexes 0 to 5, black, white, yellow, red, blue, green;
// red in bits 23:16), with ties going to the lower index. The winning 4-bit code is packed
// two per byte, first pixel in the high nibble; a final pixel that arrives alone gives a
// byte with a zero low nibble. One pixel is accepted every clock while bytes are taken;
// each pixel passes through the input register and four stages of distance and compare
// logic, and the byte that it completes, if any, is then held in the packing register.
// Write the palette only while the block is idle.
module palette_quantize_nibble_pack import pqnp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [ColorW-1:0]    csr_data,
   pqnp_req_if.sink             req_chan,
   pqnp_rsp_if.source           rsp_chan
);

   palette_type   palette_ff, palette_in;
   pixel_type     req_pixel;
   logic          code_valid;
   logic          code_ready;
   code_item_type code_item;
   logic          code_fire;

   code_type      held_ff, held_in;
   logic          half_full_ff, half_full_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [ByteW-1:0] rsp_byte_ff, rsp_byte_in;
   logic          rsp_final_ff, rsp_final_in;

   always_comb begin
      palette_in = palette_ff;
      for (int i = 0; i < NumEntries; i++) begin
         if (csr_write_en && csr_index == CsrIndexW'(i)) begin
            palette_in[i] = csr_data;
         end
      end
   end

   assign req_pixel.red         = req_chan.red;
   assign req_pixel.green       = req_chan.green;
   assign req_pixel.blue        = req_chan.blue;
   assign req_pixel.final_pixel = req_chan.final_pixel;

   pqnp_nearest u_nearest (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_pixel  (req_pixel),
      .palette   (palette_ff),
      .out_valid (code_valid),
      .out_ready (code_ready),
      .out_item  (code_item)
   );

   assign code_ready = !rsp_valid_ff || rsp_chan.ready;
   assign code_fire  = code_valid && code_ready;

   always_comb begin
      held_in      = held_ff;
      half_full_in = half_full_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_final_in = rsp_final_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (code_fire) begin
         if (half_full_ff) begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = {held_ff, code_item.code};
            rsp_final_in = code_item.final_pixel;
            held_in      = CodePad;
            half_full_in = 1'b0;
         end else if (code_item.final_pixel) begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = {code_item.code, CodePad};
            rsp_final_in = 1'b1;
         end else begin
            rsp_valid_in = 1'b0;
            held_in      = code_item.code;
            half_full_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         palette_ff   <= EntryReset;
         held_ff      <= CodePad;
         half_full_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         palette_ff   <= palette_in;
         held_ff      <= held_in;
         half_full_ff <= half_full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_byte_ff  <= rsp_byte_in;
      rsp_final_ff <= rsp_final_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.packed_byte = rsp_byte_ff;
   assign rsp_chan.final_byte  = rsp_final_ff;

   assert property (@(posedge clock) disable iff (reset)
      (code_fire && half_full_ff) |=> rsp_valid_ff && !half_full_ff)
      else $error("completed pair did not produce a byte");

   assert property (@(posedge clock) disable iff (reset)
      (code_fire && !half_full_ff && !code_item.final_pixel) |=> half_full_ff && !rsp_valid_ff)
      else $error("first code of a pair was not held");

   assert property (@(posedge clock) disable iff (reset)
      (code_fire && !half_full_ff && code_item.final_pixel)
         |=> rsp_valid_ff && rsp_final_ff && rsp_byte_ff[CodeW-1:0] == CodePad)
      else $error("lone final pixel was not padded");

endmodule

### sim/tb_palette_quantize_nibble_pack.sv
module tb_palette_quantize_nibble_pack;
   timeunit 1ns;
   timeprecision 1ps;

   import pqnp_pkg::*;

   localparam int DrainCycles  = 12;
   localparam int CycleLimit   = 400000;
   localparam int RandomPhases = 10;
   localparam int PhaseItems   = 127;
   localparam int MaxReports   = 200;
   localparam int ChanMax      = 2 ** ChanW - 1;

   localparam logic [CsrIndexW-1:0] RegBlack     = 3'd0;
   localparam logic [CsrIndexW-1:0] RegWhite     = 3'd1;
   localparam logic [CsrIndexW-1:0] RegYellow    = 3'd2;
   localparam logic [CsrIndexW-1:0] RegRed       = 3'd3;
   localparam logic [CsrIndexW-1:0] RegBlue      = 3'd4;
   localparam logic [CsrIndexW-1:0] RegGreen     = 3'd5;
   localparam logic [CsrIndexW-1:0] RegSpareLow  = 3'd6;
   localparam logic [CsrIndexW-1:0] RegSpareHigh = 3'd7;

   typedef struct packed {
      logic [ByteW-1:0] packed_byte;
      logic             final_byte;
   } byte_item_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_en;
   logic [CsrIndexW-1:0] csr_index;
   color_type            csr_data;

   pqnp_req_if req_bus ();
   pqnp_rsp_if rsp_bus ();

   palette_quantize_nibble_pack dut (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_chan     (req_bus),
      .rsp_chan     (rsp_bus)
   );

   pixel_type     pending_pixels[$];
   byte_item_type expected_bytes[$];
   color_type     palette_regs[NumEntries];
   color_type     next_palette[NumEntries];
   code_type      held_code;
   bit            pair_held;
   int            req_idle_pct;
   int            rsp_idle_pct;
   int            mismatch_count = 0;
   int            cycle_count = 0;
   pixel_type     next_pixel;
   pixel_type     accepted_pixel;
   byte_item_type wanted_byte;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MaxReports) begin
         $display("ERROR at cycle %0d: %s", cycle_count, what);
      end
   endtask

   function automatic code_type closest_code(chan_type r, chan_type g, chan_type b);
      int unsigned best_dist;
      int unsigned sum_dist;
      code_type    best;
      int          dr;
      int          dg;
      int          db;
      best_dist = 0;
      best = EntryCode[0];
      for (int i = 0; i < NumEntries; i++) begin
         dr = int'(r) - int'(palette_regs[i][2*ChanW +: ChanW]);
         dg = int'(g) - int'(palette_regs[i][ChanW +: ChanW]);
         db = int'(b) - int'(palette_regs[i][0 +: ChanW]);
         sum_dist = dr * dr + dg * dg + db * db;
         if (i == 0 || sum_dist < best_dist) begin
            best_dist = sum_dist;
            best = EntryCode[i];
         end
      end
      return best;
   endfunction

   function automatic void predict_pixel(pixel_type p);
      code_type      code;
      byte_item_type item;
      code = closest_code(p.red, p.green, p.blue);
      if (pair_held) begin
         item.packed_byte = {held_code, code};
         item.final_byte = p.final_pixel;
         expected_bytes = {expected_bytes, item};
         pair_held = 1'b0;
         held_code = '0;
      end else if (p.final_pixel) begin
         item.packed_byte = {code, CodePad};
         item.final_byte = 1'b1;
         expected_bytes = {expected_bytes, item};
      end else begin
         held_code = code;
         pair_held = 1'b1;
      end
   endfunction

   function automatic void add_pixel(chan_type r, chan_type g, chan_type b, logic fp);
      pixel_type p;
      p.red = r;
      p.green = g;
      p.blue = b;
      p.final_pixel = fp;
      pending_pixels = {pending_pixels, p};
   endfunction

   function automatic chan_type jitter(chan_type c);
      int v;
      v = int'(c) + int'($urandom_range(6)) - 3;
      if (v < 0) v = 0;
      if (v > ChanMax) v = ChanMax;
      return chan_type'(v);
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type p;
      color_type near;
      color_type any;
      int        pick;
      pick = $urandom_range(99);
      near = palette_regs[$urandom_range(NumEntries - 1)];
      any = color_type'($urandom);
      if (pick < 55) begin
         {p.red, p.green, p.blue} = any;
      end else if (pick < 80) begin
         p.red = jitter(near[2*ChanW +: ChanW]);
         p.green = jitter(near[ChanW +: ChanW]);
         p.blue = jitter(near[0 +: ChanW]);
      end else if (pick < 90) begin
         {p.red, p.green, p.blue} = near;
      end else begin
         p.red = $urandom_range(1) ? chan_type'(ChanMax) : '0;
         p.green = $urandom_range(1) ? chan_type'(ChanMax) : '0;
         p.blue = $urandom_range(1) ? chan_type'(ChanMax) : '0;
      end
      p.final_pixel = 1'b0;
      return p;
   endfunction

   task automatic write_reg(input logic [CsrIndexW-1:0] idx, input color_type value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      if (idx < NumEntries) palette_regs[idx] = value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic load_palette();
      write_reg(RegBlack, next_palette[RegBlack]);
      write_reg(RegWhite, next_palette[RegWhite]);
      write_reg(RegYellow, next_palette[RegYellow]);
      write_reg(RegRed, next_palette[RegRed]);
      write_reg(RegBlue, next_palette[RegBlue]);
      write_reg(RegGreen, next_palette[RegGreen]);
      write_reg(RegSpareLow, color_type'($urandom));
      write_reg(RegSpareHigh, color_type'($urandom));
   endtask

   // Waits until the sender is empty and every byte has come back, then lets
   // any pixel that produced no byte clear the pipeline.
   task automatic settle();
      while (!(pending_pixels.size() == 0 && !req_bus.valid && expected_bytes.size() == 0))
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            accepted_pixel.red = req_bus.red;
            accepted_pixel.green = req_bus.green;
            accepted_pixel.blue = req_bus.blue;
            accepted_pixel.final_pixel = req_bus.final_pixel;
            predict_pixel(accepted_pixel);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_pixels.size() > 0 && $urandom_range(99) >= req_idle_pct) begin
               next_pixel = pending_pixels.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.red <= next_pixel.red;
               req_bus.green <= next_pixel.green;
               req_bus.blue <= next_pixel.blue;
               req_bus.final_pixel <= next_pixel.final_pixel;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h final %0b",
                                      rsp_bus.packed_byte, rsp_bus.final_byte));
         end else begin
            wanted_byte = expected_bytes.pop_front();
            if (rsp_bus.packed_byte !== wanted_byte.packed_byte) begin
               report_mismatch($sformatf("packed_byte %02h, expected %02h",
                                         rsp_bus.packed_byte, wanted_byte.packed_byte));
            end
            if (rsp_bus.final_byte !== wanted_byte.final_byte) begin
               report_mismatch($sformatf("final_byte %0b, expected %0b",
                                         rsp_bus.final_byte, wanted_byte.final_byte));
            end
         end
      end
      rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int        count;
      int        len;
      bit        noisy;
      pixel_type p;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.red = '0;
      req_bus.green = '0;
      req_bus.blue = '0;
      req_bus.final_pixel = 1'b0;
      rsp_bus.ready = 1'b0;
      req_idle_pct = 25;
      rsp_idle_pct = 25;
      pair_held = 1'b0;
      held_code = '0;
      for (int i = 0; i < NumEntries; i++) palette_regs[i] = EntryReset[i];
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // The palette as it comes out of reset: every color exactly, mid grays,
      // an even image, two single-pixel images and a two-pixel image.
      add_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      add_pixel(8'hFF, 8'hFF, 8'h00, 1'b0);
      add_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
      add_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
      add_pixel(8'h00, 8'hFF, 8'h00, 1'b1);
      add_pixel(8'h80, 8'h80, 8'h80, 1'b1);
      add_pixel(8'h7F, 8'h7F, 8'h7F, 1'b1);
      add_pixel(8'hFF, 8'h80, 8'h00, 1'b0);
      add_pixel(8'h00, 8'h80, 8'h80, 1'b1);
      settle();

      // All entries equal, so every pixel ties and black must win.
      foreach (next_palette[i]) next_palette[i] = '0;
      load_palette();
      add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      add_pixel(8'h12, 8'h34, 8'h56, 1'b1);
      add_pixel(8'hAB, 8'hCD, 8'hEF, 1'b1);
      settle();

      next_palette[RegBlack] = 24'hFFFFFF;
      next_palette[RegWhite] = 24'hFFFFFF;
      next_palette[RegYellow] = 24'h000000;
      next_palette[RegRed] = 24'h000000;
      next_palette[RegBlue] = 24'h00FFFF;
      next_palette[RegGreen] = 24'hFF00FF;
      load_palette();
      add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      add_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      add_pixel(8'hF0, 8'h10, 8'hF0, 1'b0);
      add_pixel(8'h10, 8'hF0, 8'hF0, 1'b1);
      settle();

      for (int phase = 0; phase < RandomPhases; phase++) begin
         for (int i = 0; i < NumEntries; i++) begin
            case (phase % 4)
               0: next_palette[i] = color_type'($urandom);
               1: next_palette[i] = EntryReset[i];
               2: begin
                  if (i > 0 && $urandom_range(1))
                     next_palette[i] = next_palette[$urandom_range(i - 1)];
                  else
                     next_palette[i] = color_type'($urandom);
               end
               default: begin
                  for (int c = 0; c < NumChans; c++)
                     next_palette[i][c*ChanW +: ChanW] =
                        $urandom_range(1) ? chan_type'(ChanMax) : '0;
               end
            endcase
         end
         load_palette();
         req_idle_pct = (phase == 4) ? 0 : 25;
         rsp_idle_pct = (phase == 4) ? 0 : 25;
         count = 0;
         while (count < PhaseItems) begin
            len = $urandom_range(20, 1);
            noisy = ($urandom_range(9) == 0);
            for (int k = 0; k < len; k++) begin
               p = random_pixel();
               p.final_pixel = noisy ? logic'($urandom_range(1)) : (k == len - 1);
               pending_pixels = {pending_pixels, p};
               count++;
            end
         end
         settle();
      end

      if (mismatch_count == 0 && expected_bytes.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
